// File: rtl/core/chrl_pkg.sv
// ----------------------------------------------------------------------------
// chrl_pkg
// Types and constants shared by the hash ring lookup unit: ring geometry,
// item structs, register indexes and the lookup state machine encoding.
// ----------------------------------------------------------------------------
package chrl_pkg;

    // ring geometry
    localparam int RING_DEPTH = 256;
    localparam int NODE_BITS  = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int N_W        = IDX_W + 1;
    localparam int ADR_W      = IDX_W + 1;
    localparam int MEM_DEPTH  = 2 * RING_DEPTH;

    // field widths
    localparam int LOC_W      = 64;
    localparam int ENTRY_W    = 8;
    localparam int NODE_W     = 16;
    localparam int CNT_W      = 9;
    localparam int CNT_CMP_W  = (N_W > CNT_W) ? N_W : CNT_W;
    localparam int ENT_CMP_W  = (N_W > ENTRY_W) ? N_W : ENTRY_W;

    // configuration port
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;

    typedef enum logic [1:0] {
        REG_BUCKET_MASK = 2'd0,
        REG_CUR_COUNT   = 2'd1,
        REG_NEW_COUNT   = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    // command and ring codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;
    localparam logic RING_NEW   = 1'b0;
    localparam logic RING_CUR   = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic                command;
        logic                ring_select;
        logic [ENTRY_W-1:0]  entry_index;
        logic [LOC_W-1:0]    ring_location;
        logic [NODE_W-1:0]   owner_node;
        logic [LOC_W-1:0]    page_id;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0]   node_id;
        logic                status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_MID,
        S_OWN,
        S_PUSH
    } t_state;

endpackage

// File: rtl/core/consistent_hash_ring_lookup_unit.sv
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_unit
// Two sorted hash rings (current and new) held in on-chip memories. Write
// items load one ring slot; lookup items mask the page id into a bucket id
// and bisect the selected ring for the owner of the greatest location not
// above it, wrapping to the last location below the first.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                payload
//  -------   ---------  -----------------------  ------------------------
//  in        in         i_in_valid / o_in_stall  i_in_item  (t_in_item)
//  out       out        o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg       in         psel/penable/pwrite      paddr, pwdata, prdata
//
//  one item at a time; a write item stores its slot, then pushes OK status;
//  an empty-ring lookup pushes EMPTY status; a lookup reads the first and last
//  locations, makes at most ceil(log2(count - 1)) bisection probes (each a
//  dependent location read), then reads the owner of the entry found
//  the finished result sits in an output register; the next item is taken
//  while it waits, but a second result holds in the engine until it drains
//  synchronous active-low reset sets state, output valid and configuration
//  registers only; payload registers and ring memories are not cleared
//
module consistent_hash_ring_lookup_unit
    import chrl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    // result output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // configuration registers
    logic [LOC_W-1:0] r_bucket_mask;
    logic [CNT_W-1:0] r_cur_cnt;
    logic [CNT_W-1:0] r_new_cnt;

    // control registers
    t_state           r_state,      n_state;
    logic             r_sel,        n_sel;
    logic [LOC_W-1:0] r_id,         n_id;
    logic [IDX_W-1:0] r_lo,         n_lo;
    logic [IDX_W-1:0] r_hi,         n_hi;
    logic [IDX_W-1:0] r_mid,        n_mid;
    logic             r_below,      n_below;
    logic             r_res_status, n_res_status;
    logic             r_out_valid,  n_out_valid;
    t_out_item        r_out_item,   n_out_item;

    // memories
    logic [LOC_W-1:0]     loc_mem [MEM_DEPTH];
    logic [NODE_BITS-1:0] own_mem [MEM_DEPTH];
    logic [LOC_W-1:0]     r_loc_rd;
    logic [NODE_BITS-1:0] r_own_rd;

    logic                 mem_we;
    logic [ADR_W-1:0]     mem_waddr;
    logic                 loc_re;
    logic [ADR_W-1:0]     loc_raddr;
    logic                 own_re;
    logic [ADR_W-1:0]     own_raddr;

    // helpers
    logic                 in_acc;
    logic                 out_free;
    logic                 cfg_wr;
    logic [CNT_W-1:0]     sel_cnt;
    logic [N_W-1:0]       ring_n;
    logic [LOC_W-1:0]     in_id;
    logic                 slot_ok;
    logic [IDX_W-1:0]     b_lo;
    logic [IDX_W-1:0]     b_hi;
    logic [IDX_W-1:0]     b_diff;
    logic [IDX_W-1:0]     b_mid;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_mask <= '1;
            r_cur_cnt     <= '0;
            r_new_cnt     <= '0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:3]))
                REG_BUCKET_MASK: r_bucket_mask <= pwdata;
                REG_CUR_COUNT:   r_cur_cnt     <= pwdata[CNT_W-1:0];
                REG_NEW_COUNT:   r_new_cnt     <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:3]))
            REG_BUCKET_MASK: prdata = r_bucket_mask;
            REG_CUR_COUNT:   prdata = PDATA_W'(r_cur_cnt);
            REG_NEW_COUNT:   prdata = PDATA_W'(r_new_cnt);
            default:         prdata = '0;
        endcase
    end

    // ring size of the incoming lookup, saturated to the ring depth
    assign sel_cnt = (i_in_item.ring_select == RING_CUR) ? r_cur_cnt : r_new_cnt;
    assign ring_n  = (CNT_CMP_W'(sel_cnt) > CNT_CMP_W'(RING_DEPTH)) ?
                     N_W'(RING_DEPTH) : N_W'(sel_cnt);
    assign in_id   = i_in_item.page_id & r_bucket_mask;
    assign slot_ok = ENT_CMP_W'(i_in_item.entry_index) < ENT_CMP_W'(RING_DEPTH);

    // ring memories, one read port each, registered read data
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            loc_mem[mem_waddr] <= i_in_item.ring_location;
            own_mem[mem_waddr] <= NODE_BITS'(i_in_item.owner_node);
        end
        if (loc_re) begin
            r_loc_rd <= loc_mem[loc_raddr];
        end
        if (own_re) begin
            r_own_rd <= own_mem[own_raddr];
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sel        <= n_sel;
        r_id         <= n_id;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_below      <= n_below;
        r_res_status <= n_res_status;
        r_out_item   <= n_out_item;
    end

    // next state, memory accesses and bisection step
    always_comb begin
        n_state      = r_state;
        n_sel        = r_sel;
        n_id         = r_id;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_below      = r_below;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_item   = r_out_item;
        mem_we       = 1'b0;
        mem_waddr    = {i_in_item.ring_select, IDX_W'(i_in_item.entry_index)};
        loc_re       = 1'b0;
        loc_raddr    = {r_sel, r_hi};
        own_re       = 1'b0;
        own_raddr    = {r_sel, r_hi};
        b_lo         = r_lo;
        b_hi         = r_hi;

        // bounds after the current compare
        if (r_state == S_MID) begin
            if (r_loc_rd <= r_id) begin
                b_lo = r_mid;
            end else begin
                b_hi = r_mid;
            end
        end
        b_diff = b_hi - b_lo;
        b_mid  = b_lo + (b_diff >> 1);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sel = i_in_item.ring_select;
                    n_id  = in_id;
                    n_lo  = '0;
                    n_hi  = IDX_W'(ring_n - N_W'(1));
                    if (i_in_item.command == CMD_WRITE) begin
                        mem_we       = slot_ok;
                        n_res_status = STATUS_OK;
                        n_state      = S_PUSH;
                    end else if (ring_n == '0) begin
                        n_res_status = STATUS_EMPTY;
                        n_state      = S_PUSH;
                    end else begin
                        // fetch the first location
                        loc_re    = 1'b1;
                        loc_raddr = {i_in_item.ring_select, {IDX_W{1'b0}}};
                        n_state   = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                // wrap check against the first location, fetch the last
                n_below   = r_id < r_loc_rd;
                loc_re    = 1'b1;
                loc_raddr = {r_sel, r_hi};
                n_state   = S_LAST;
            end
            S_LAST, S_MID: begin
                if (r_state == S_LAST && (r_below || r_id >= r_loc_rd)) begin
                    // below first or at/above last: owner of last entry
                    own_re    = 1'b1;
                    own_raddr = {r_sel, r_hi};
                    n_state   = S_OWN;
                end else begin
                    n_lo = b_lo;
                    n_hi = b_hi;
                    if (b_diff > IDX_W'(1)) begin
                        loc_re    = 1'b1;
                        loc_raddr = {r_sel, b_mid};
                        n_mid     = b_mid;
                        n_state   = S_MID;
                    end else begin
                        own_re    = 1'b1;
                        own_raddr = {r_sel, b_lo};
                        n_state   = S_OWN;
                    end
                end
            end
            S_OWN: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out_item.node_id = NODE_W'(r_own_rd);
                    n_out_item.status  = STATUS_OK;
                    n_state            = S_IDLE;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out_item.node_id = '0;
                    n_out_item.status  = r_res_status;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // a probe always lies strictly inside the bisection bounds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID) |-> (r_lo < r_mid && r_mid < r_hi))
    else $error("bisection probe outside bounds");

    // bounds never cross while searching
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIRST || r_state == S_LAST || r_state == S_MID) |-> (r_lo <= r_hi))
    else $error("bisection bounds crossed");

    // an accepted item always leaves the idle state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
    else $error("accepted item not started");

    // an empty-ring result carries no owner
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == STATUS_EMPTY) |-> (o_out_item.node_id == '0))
    else $error("empty ring result with nonzero node");

    // a waiting result is not overwritten by the engine
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
    else $error("stalled result overwritten");
`endif

endmodule
